>>> src/gdfw_pkg.sv
// Shared types, sizes and codes for the graph depth-first walk core.
// Used by gdfw_node_ram, gdfw_walk and graph_depth_first_walk_core; no dependencies.
package gdfw_pkg;

  // Pool and graph sizes.
  localparam int MAX_VERTICES   = 16;
  localparam int MAX_LIST_NODES = 128;
  localparam int RESULT_SLOTS   = 16;

  // Field and register widths.
  localparam int VTX_W  = 4;
  localparam int CNT_W  = 5;
  localparam int ACT_W  = 2;
  localparam int STAT_W = 2;

  // Derived widths. A pointer can hold the null code MAX_LIST_NODES.
  localparam int NODE_AW = $clog2(MAX_LIST_NODES);
  localparam int PTR_W   = $clog2(MAX_LIST_NODES + 1);
  localparam int DEPTH_W = $clog2(MAX_VERTICES + 1);
  localparam int SIDX_W  = $clog2(MAX_VERTICES);
  localparam int EMIT_W  = $clog2(RESULT_SLOTS + 1);

  localparam logic [PTR_W-1:0] NULL_PTR      = PTR_W'(MAX_LIST_NODES);
  localparam logic [CNT_W-1:0] VCOUNT_RESET  = CNT_W'(16);

  // Action codes.
  localparam logic [ACT_W-1:0] ACT_ADD    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

  // Status codes.
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EDGE_A,
    S_EDGE_B,
    S_TOP,
    S_READ,
    S_FINISH
  } walk_state_t;

  // One list node: the neighbor it names and the next node of its list.
  typedef struct packed {
    logic [VTX_W-1:0] neighbor;
    logic [PTR_W-1:0] link;
  } node_t;

  typedef struct packed {
    logic               en;
    logic [NODE_AW-1:0] addr;
    node_t              data;
  } ram_wr_t;

  typedef struct packed {
    logic              valid;
    logic [VTX_W-1:0]  vertex;
    logic              last;
    logic [STAT_W-1:0] status;
  } result_t;

endpackage

>>> src/gdfw_node_ram.sv
// Node pool memory: neighbor and link of every adjacency list node.
// One write port, one read port with registered read data; uses gdfw_pkg.
module gdfw_node_ram import gdfw_pkg::*; (
  input  logic               clk,
  input  ram_wr_t            wr,
  input  logic [NODE_AW-1:0] rd_addr,
  output node_t              rd_data
);

  node_t mem [MAX_LIST_NODES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> src/gdfw_walk.sv
// Sequencer for edge insertion, clearing and the depth-first walk.
// Holds list heads, visited marks and the cursor stack; drives gdfw_node_ram; uses gdfw_pkg.
module gdfw_walk import gdfw_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [ACT_W-1:0]   action,
  input  logic [VTX_W-1:0]   first_vertex,
  input  logic [VTX_W-1:0]   second_vertex,
  input  logic [CNT_W-1:0]   vertex_count,
  output logic               busy,
  output ram_wr_t            ram_wr,
  output logic [NODE_AW-1:0] ram_rd_addr,
  input  node_t              ram_rd_data,
  output result_t            result
);

  walk_state_t state, state_next;

  logic [VTX_W-1:0]        op_a;
  logic [VTX_W-1:0]        op_b;
  logic [PTR_W-1:0]        nodes_used;
  logic [PTR_W-1:0]        head_ptr [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] head_vld;
  logic [MAX_VERTICES-1:0] seen;
  logic [PTR_W-1:0]        walk_stack [MAX_VERTICES];
  logic [DEPTH_W-1:0]      depth;
  logic [VTX_W-1:0]        pend_v;
  logic [EMIT_W-1:0]       emit_cnt;

  logic [CNT_W-1:0]  active;
  logic              accept;
  logic              a_ok;
  logic              b_ok;
  logic              pool_ok;
  logic [SIDX_W-1:0] top_idx;
  logic [SIDX_W-1:0] push_idx;
  logic [PTR_W-1:0]  top_ptr;
  logic              top_null;
  logic [VTX_W-1:0]  w;
  logic              w_take;

  function automatic logic [PTR_W-1:0] head_of(input logic [VTX_W-1:0] v);
    return head_vld[v] ? head_ptr[v] : NULL_PTR;
  endfunction

  assign active   = (vertex_count > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : vertex_count;
  assign accept   = start && (state == S_IDLE);
  assign a_ok     = CNT_W'(first_vertex) < active;
  assign b_ok     = CNT_W'(second_vertex) < active;
  assign pool_ok  = ((PTR_W + 1)'(nodes_used) + (PTR_W + 1)'(2)) <=
                    (PTR_W + 1)'(MAX_LIST_NODES);
  assign top_idx  = SIDX_W'(depth - DEPTH_W'(1));
  assign push_idx = depth[SIDX_W-1:0];
  assign top_ptr  = walk_stack[top_idx];
  assign top_null = top_ptr >= NULL_PTR;
  assign w        = ram_rd_data.neighbor;
  assign w_take   = (CNT_W'(w) < active) && !seen[w] && (depth < DEPTH_W'(MAX_VERTICES));

  assign ram_rd_addr = top_ptr[NODE_AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    ram_wr.en   = 1'b0;
    ram_wr.addr = nodes_used[NODE_AW-1:0];
    ram_wr.data = '{neighbor: op_b, link: head_of(op_a)};
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (action)
            ACT_ADD: begin
              if (a_ok && b_ok && pool_ok) begin
                state_next = S_EDGE_A;
              end
            end
            ACT_SEARCH: begin
              if (a_ok) begin
                state_next = S_TOP;
              end
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_EDGE_A: begin
        ram_wr.en  = 1'b1;
        state_next = S_EDGE_B;
      end
      S_EDGE_B: begin
        ram_wr.en   = 1'b1;
        ram_wr.data = '{neighbor: op_a, link: head_of(op_b)};
        state_next  = S_IDLE;
      end
      S_TOP: begin
        if (depth == '0) begin
          state_next = S_FINISH;
        end else if (!top_null) begin
          state_next = S_READ;
        end
      end
      S_READ:   state_next = S_TOP;
      S_FINISH: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      nodes_used   <= '0;
      head_vld     <= '0;
      seen         <= '0;
      depth        <= '0;
      emit_cnt     <= '0;
      result.valid <= 1'b0;
    end else begin
      result.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            op_a <= first_vertex;
            op_b <= second_vertex;
            case (action)
              ACT_ADD: begin
                if (!(a_ok && b_ok)) begin
                  result <= '{valid: 1'b1, vertex: '0, last: 1'b1, status: STAT_RANGE};
                end else if (!pool_ok) begin
                  result <= '{valid: 1'b1, vertex: '0, last: 1'b1, status: STAT_FULL};
                end
              end
              ACT_SEARCH: begin
                if (!a_ok) begin
                  result <= '{valid: 1'b1, vertex: '0, last: 1'b1, status: STAT_RANGE};
                end else begin
                  // Only the start vertex is marked when a walk begins.
                  seen          <= MAX_VERTICES'(1) << first_vertex;
                  pend_v        <= first_vertex;
                  emit_cnt      <= EMIT_W'(1);
                  walk_stack[0] <= head_of(first_vertex);
                  depth         <= DEPTH_W'(1);
                end
              end
              ACT_CLEAR: begin
                head_vld   <= '0;
                nodes_used <= '0;
                result     <= '{valid: 1'b1, vertex: '0, last: 1'b1, status: STAT_OK};
              end
              default: ;
            endcase
          end
        end
        S_EDGE_A: begin
          head_ptr[op_a] <= nodes_used;
          head_vld[op_a] <= 1'b1;
          nodes_used     <= nodes_used + PTR_W'(1);
        end
        S_EDGE_B: begin
          head_ptr[op_b] <= nodes_used;
          head_vld[op_b] <= 1'b1;
          nodes_used     <= nodes_used + PTR_W'(1);
          result         <= '{valid: 1'b1, vertex: '0, last: 1'b1, status: STAT_OK};
        end
        S_TOP: begin
          if (depth != '0 && top_null) begin
            depth <= depth - DEPTH_W'(1);
          end
        end
        S_READ: begin
          walk_stack[top_idx] <= ram_rd_data.link;
          if (w_take) begin
            seen[w]              <= 1'b1;
            walk_stack[push_idx] <= head_of(w);
            depth                <= depth + DEPTH_W'(1);
            // The held visit goes out only once a later visit proves it is not the last.
            if (emit_cnt < EMIT_W'(RESULT_SLOTS)) begin
              result   <= '{valid: 1'b1, vertex: pend_v, last: 1'b0, status: STAT_OK};
              pend_v   <= w;
              emit_cnt <= emit_cnt + EMIT_W'(1);
            end
          end
        end
        S_FINISH: begin
          result <= '{valid: 1'b1, vertex: pend_v, last: 1'b1, status: STAT_OK};
        end
        default: ;
      endcase
    end
  end

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= DEPTH_W'(MAX_VERTICES))
    else $error("cursor stack deeper than the vertex count");

  a_read_after_top: assert property (@(posedge clk) disable iff (rst)
    state == S_READ |-> $past(state) == S_TOP)
    else $error("node check without a preceding read");

  a_edge_pair: assert property (@(posedge clk) disable iff (rst)
    state == S_EDGE_B |-> $past(state) == S_EDGE_A)
    else $error("second edge node written without the first");

  a_error_is_last: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.status != STAT_OK |-> result.last)
    else $error("error result not flagged as last");

  a_pool_bound: assert property (@(posedge clk) disable iff (rst)
    nodes_used <= PTR_W'(MAX_LIST_NODES))
    else $error("node pool overrun");

endmodule

>>> src/graph_depth_first_walk_core.sv
// Graph depth-first walk core: top level with the vertex count register.
// Instantiates gdfw_walk and gdfw_node_ram; uses gdfw_pkg.
//
// The core keeps an undirected graph as adjacency lists in a 128-node pool and
// answers three kinds of transaction: add edge, depth-first search and clear.
// A transaction is taken at a rising edge where start is high and busy is low;
// busy stays high until the core can take the next one. Every result appears
// on visited_vertex, last_of_run and status for exactly one cycle, marked by
// result_valid, and the receiver cannot hold it off. Clear and rejected
// transactions leave the core idle and their result follows on the next cycle.
// An accepted edge passes through S_EDGE_A and S_EDGE_B, which write the two
// list nodes through the single write port of the node memory. For each list
// node on the lists of the visited vertices, a search reads the node memory,
// whose read data is registered, in S_TOP and checks the neighbor and pushes
// it in S_READ; each exhausted list is popped in S_TOP. Each visit is reported
// once the next visit is found, and the final one after the walk ends, so that
// it can carry last_of_run. The vertex count register is written with cfg_write
// and cfg_wdata and resets to 16; the user must write it only while idle, as
// the block itself does not enforce this. Unused action code 3 is dropped
// without a result.
module graph_depth_first_walk_core import gdfw_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [CNT_W-1:0]  cfg_wdata,
  input  logic              start,
  output logic              busy,
  input  logic [ACT_W-1:0]  action,
  input  logic [VTX_W-1:0]  first_vertex,
  input  logic [VTX_W-1:0]  second_vertex,
  output logic              result_valid,
  output logic [VTX_W-1:0]  visited_vertex,
  output logic              last_of_run,
  output logic [STAT_W-1:0] status
);

  logic [CNT_W-1:0]   vertex_count;
  ram_wr_t            ram_wr;
  logic [NODE_AW-1:0] ram_rd_addr;
  node_t              ram_rd_data;
  result_t            result;

  // Vertex count register; vertices at or above min(count, 16) are rejected.
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VCOUNT_RESET;
    end else if (cfg_write) begin
      vertex_count <= cfg_wdata;
    end
  end

  gdfw_walk u_walk (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .action        (action),
    .first_vertex  (first_vertex),
    .second_vertex (second_vertex),
    .vertex_count  (vertex_count),
    .busy          (busy),
    .ram_wr        (ram_wr),
    .ram_rd_addr   (ram_rd_addr),
    .ram_rd_data   (ram_rd_data),
    .result        (result)
  );

  gdfw_node_ram u_node_ram (
    .clk     (clk),
    .wr      (ram_wr),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Result fields leave the output register directly.
  assign result_valid   = result.valid;
  assign visited_vertex = result.vertex;
  assign last_of_run    = result.last;
  assign status         = result.status;

endmodule
